// File: src/ahfc_pkg.sv
package ahfc_pkg;

  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HEAD = 1'b0,
    REG_TAIL = 1'b1
  } cfg_reg_t;

  localparam logic [7:0]  HEAD_RESET = 8'hAA;
  localparam logic [7:0]  TAIL_RESET = 8'h55;
  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'hA001;
  localparam logic [7:0]  CHAR_BASE  = 8'h30;
  localparam logic [7:0]  CHAR_TERM  = 8'h00;
  localparam int unsigned MIN_BYTES  = 5;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SHORT     = 3'd1,
    ST_BAD_HEAD  = 3'd2,
    ST_BAD_LEN   = 3'd3,
    ST_BAD_CRC   = 3'd4,
    ST_BAD_TAIL  = 3'd5,
    ST_OVERLONG  = 3'd6
  } status_t;

  // input stage to frame core
  typedef struct packed {
    logic       take;
    logic [7:0] hex_char;
  } char_item_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  byte_count;
    logic [15:0] crc_value;
  } verdict_t;

  // ASCII hex digit to nibble, wrapping like 8-bit arithmetic
  function automatic logic [7:0] char_value(input logic [7:0] c);
    logic [7:0] s;
    s = c - CHAR_BASE;
    if (s > 8'd9) begin
      s = s - 8'd7;
    end
    return s;
  endfunction

  // CRC-16/MODBUS, one byte, reflected
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] crc;
    crc = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (crc[0]) begin
        crc = (crc >> 1) ^ CRC_POLY;
      end else begin
        crc = crc >> 1;
      end
    end
    return crc;
  endfunction

endpackage

// File: src/ahfc_char_if.sv
interface ahfc_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] hex_char;

  modport source (output valid, output hex_char, input ready);
  modport sink (input valid, input hex_char, output ready);
endinterface

// File: src/ahfc_result_if.sv
interface ahfc_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [7:0]  byte_count;
  logic [15:0] crc_value;

  modport source (output valid, output status, output byte_count, output crc_value,
                  input ready);
  modport sink (input valid, input status, input byte_count, input crc_value,
                output ready);
endinterface

// File: src/ahfc_in_stage.sv
module ahfc_in_stage
  import ahfc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  ahfc_char_if.sink   char_in,
  input  logic        out_free,
  output char_item_t  item
);

  logic       s1_valid;
  logic [7:0] s1_char;
  logic       s1_is_term;
  logic       s1_take;

  assign s1_is_term = (s1_char == CHAR_TERM);
  // a terminator needs the result register; plain characters never wait
  assign s1_take = s1_valid && (!s1_is_term || out_free);
  assign char_in.ready = !s1_valid || s1_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (char_in.ready) begin
      s1_valid <= char_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (char_in.ready && char_in.valid) begin
      s1_char <= char_in.hex_char;
    end
  end

  assign item.take     = s1_take;
  assign item.hex_char = s1_char;

endmodule

// File: src/ahfc_frame_core.sv
module ahfc_frame_core
  import ahfc_pkg::*;
#(
  parameter int unsigned MAX_CHARS = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  char_item_t item,
  input  logic [7:0] head_value,
  input  logic [7:0] tail_value,
  output logic       term_fire,
  output verdict_t   verdict
);

  localparam int unsigned CNT_W = $clog2(MAX_CHARS + 1);
  localparam int unsigned NB_W  = CNT_W - 1;

  logic [CNT_W-1:0] char_counter;
  logic [7:0]       pending_nibble;
  logic [7:0]       recent_bytes [3];
  logic [7:0]       first_two_bytes [2];
  logic [15:0]      running_crc;
  logic             overflow_flag;

  logic             is_term;
  logic             full;
  logic [NB_W-1:0]  nb;
  logic [7:0]       nib;
  logic [7:0]       new_byte;

  assign is_term   = (item.hex_char == CHAR_TERM);
  assign term_fire = item.take && is_term;
  assign full      = (char_counter == CNT_W'(MAX_CHARS));
  assign nb        = char_counter[CNT_W-1:1];
  assign nib       = char_value(item.hex_char);
  assign new_byte  = {pending_nibble[3:0], 4'h0} + nib;

  always_ff @(posedge clk) begin
    if (rst || term_fire) begin
      char_counter       <= '0;
      pending_nibble     <= '0;
      recent_bytes[0]    <= '0;
      recent_bytes[1]    <= '0;
      recent_bytes[2]    <= '0;
      first_two_bytes[0] <= '0;
      first_two_bytes[1] <= '0;
      running_crc        <= CRC_INIT;
      overflow_flag      <= 1'b0;
    end else if (item.take) begin
      if (full) begin
        overflow_flag <= 1'b1;
      end else begin
        char_counter <= char_counter + 1'b1;
        if (!char_counter[0]) begin
          pending_nibble <= nib;
        end else begin
          if (nb < NB_W'(2)) begin
            first_two_bytes[nb[0]] <= new_byte;
          end
          // the last three bytes stay out of the CRC: shift the oldest in
          if (nb >= NB_W'(3)) begin
            running_crc <= crc_byte(running_crc, recent_bytes[0]);
          end
          recent_bytes[0] <= recent_bytes[1];
          recent_bytes[1] <= recent_bytes[2];
          recent_bytes[2] <= new_byte;
        end
      end
    end
  end

  always_comb begin
    priority if (overflow_flag) begin
      verdict.status = ST_OVERLONG;
    end else if (32'(nb) < 32'(MIN_BYTES)) begin
      verdict.status = ST_SHORT;
    end else if (first_two_bytes[0] != head_value) begin
      verdict.status = ST_BAD_HEAD;
    end else if (32'(first_two_bytes[1]) != 32'(nb)) begin
      verdict.status = ST_BAD_LEN;
    end else if (recent_bytes[0] != running_crc[7:0] ||
                 recent_bytes[1] != running_crc[15:8]) begin
      verdict.status = ST_BAD_CRC;
    end else if (recent_bytes[2] != tail_value) begin
      verdict.status = ST_BAD_TAIL;
    end else begin
      verdict.status = ST_OK;
    end
    verdict.byte_count = (32'(nb) > 32'd255) ? 8'hFF : 8'(nb);
    verdict.crc_value  = running_crc;
  end

endmodule

// File: src/ascii_hex_frame_checker.sv
// ASCII-hex frame checker.
// char_in carries one character per transfer; a zero character ends the frame.
// Character pairs are decoded to bytes; at the terminator one result goes out on
// result_out: status, decoded byte count (saturated at 255) and the CRC-16/MODBUS
// over all bytes but the last three. The frame must start with head_value, carry
// its byte count in the second byte, end in CRC (low byte first) and tail_value.
// Characters past MAX_CHARS are dropped and give the overlong status.
// Throughput: one character per cycle while no terminator waits; decode and the
// unrolled 8-bit CRC update are combinational between input register and frame state.
// A terminator passes through the input register and then into the result
// register, which raises result_out.valid.
// When result_out stalls, ordinary characters keep flowing; a terminator waits
// in the input register until the result register is free, and char_in.ready
// stays low while it waits.
// Reset (rst, synchronous) clears the frame state, empties both registers and
// sets head_value to 0xAA and tail_value to 0x55. Configuration writes through
// cfg_we/cfg_index/cfg_data belong between frames, with no result pending.
module ascii_hex_frame_checker
  import ahfc_pkg::*;
#(
  parameter int unsigned MAX_CHARS = 256
) (
  input  logic                 clk,
  input  logic                 rst,
  ahfc_char_if.sink            char_in,
  ahfc_result_if.source        result_out,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [7:0] head_value;
  logic [7:0] tail_value;
  logic       out_valid;
  logic       out_free;
  verdict_t   out_data;
  verdict_t   verdict;
  char_item_t item;
  logic       term_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_value <= HEAD_RESET;
      tail_value <= TAIL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_HEAD: head_value <= cfg_data;
        REG_TAIL: tail_value <= cfg_data;
        default:  ;
      endcase
    end
  end

  assign out_free = !out_valid || result_out.ready;

  ahfc_in_stage u_in_stage (
    .clk      (clk),
    .rst      (rst),
    .char_in  (char_in),
    .out_free (out_free),
    .item     (item)
  );

  ahfc_frame_core #(
    .MAX_CHARS (MAX_CHARS)
  ) u_frame_core (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .head_value (head_value),
    .tail_value (tail_value),
    .term_fire  (term_fire),
    .verdict    (verdict)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (term_fire) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (term_fire) begin
      out_data <= verdict;
    end
  end

  assign result_out.valid      = out_valid;
  assign result_out.status     = out_data.status;
  assign result_out.byte_count = out_data.byte_count;
  assign result_out.crc_value  = out_data.crc_value;

endmodule
